/* design/pkt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions of the position keeping table.
package pkt_pkg;

  localparam int unsigned MAX_SLOTS_DEF   = 64;
  localparam int unsigned PRICE_SCALE_DEF = 1000000;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SHARE_W = 32;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned MONEY_W = 64;
  localparam int unsigned CASH_W  = 62;
  localparam int unsigned CNT_W   = 32;

  localparam logic [1:0] ACT_FILL   = 2'd0;
  localparam logic [1:0] ACT_MARK   = 2'd1;
  localparam logic [1:0] ACT_SETTLE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]          market;
    logic                      outcome;
    logic [SHARE_W-1:0]        shares;
    logic signed [MONEY_W-1:0] cost;
    logic [PRICE_W-1:0]        bid;
  } slot_t;

  function automatic logic signed [MONEY_W-1:0] sat_add(
    input logic signed [MONEY_W-1:0] a,
    input logic signed [MONEY_W-1:0] b
  );
    logic signed [MONEY_W-1:0] s;
    s = a + b;
    if (!a[MONEY_W-1] && !b[MONEY_W-1] && s[MONEY_W-1]) begin
      s = {1'b0, {(MONEY_W-1){1'b1}}};
    end else if (a[MONEY_W-1] && b[MONEY_W-1] && !s[MONEY_W-1]) begin
      s = {1'b1, {(MONEY_W-1){1'b0}}};
    end
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

/* design/pkt_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Input event channel of the position keeping table.
interface pkt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [pkt_pkg::KEY_W-1:0]      market_key;
  logic                           outcome_yes;
  logic                           sell_side;
  logic [pkt_pkg::SHARE_W-1:0]    share_count;
  logic [pkt_pkg::PRICE_W-1:0]    price_value;

  modport source (output valid, action, market_key, outcome_yes, sell_side, share_count,
                  price_value, input ready);
  modport sink (input valid, action, market_key, outcome_yes, sell_side, share_count,
                price_value, output ready);
endinterface
`default_nettype wire

/* design/pkt_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the position keeping table.
interface pkt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pkt_pkg::MONEY_W-1:0]   cash_balance;
  logic [pkt_pkg::MONEY_W-2:0]          exposure_total;
  logic signed [pkt_pkg::MONEY_W-1:0]   unrealized_total;
  logic signed [pkt_pkg::MONEY_W-1:0]   realized_total;
  logic signed [pkt_pkg::MONEY_W-1:0]   equity_value;
  logic [pkt_pkg::MONEY_W-2:0]          market_cost;
  logic [pkt_pkg::CNT_W-1:0]            closed_trades;
  logic [pkt_pkg::CNT_W-1:0]            win_trades;
  logic [pkt_pkg::CNT_W-1:0]            loss_trades;
  logic                                 table_full;

  modport source (output valid, cash_balance, exposure_total, unrealized_total,
                  realized_total, equity_value, market_cost, closed_trades, win_trades,
                  loss_trades, table_full, input ready);
  modport sink (input valid, cash_balance, exposure_total, unrealized_total,
                realized_total, equity_value, market_cost, closed_trades, win_trades,
                loss_trades, table_full, output ready);
endinterface
`default_nettype wire

/* design/position_keeping_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Position keeping table: average-cost positions per market and outcome.
//
// Events arrive on in_i as valid/ready transactions; each one produces exactly one
// result transaction on out_o carrying the running totals after that event.
// The user writes the starting cash through cfg_we_i/cfg_data_i only while the block is
// idle (not enforced by the block); a write loads it straight into the cash balance.
// The block works on one event at a time. A scan over the N used slots reads the
// slot memory once per cycle and handles each read's data when the registered read
// port returns it. A fill scans for its slot, then a sell of held shares runs a serial
// divide for the average cost; a mark or settle makes one read-modify-write pass over
// the slots. Every event ends with one more pass that sums the cost basis of its market.
// The result sits in an output register, so work on the next event starts while
// the previous result is still waiting; if the receiver stalls, the block holds
// the new result back at the end of its work until the output register drains.
// Reset clears the slot count, the money totals and the trade counters; the slot
// memory itself is not cleared, since a slot is fully written when it is allocated.
module position_keeping_table #(
  parameter int unsigned MAX_SLOTS   = pkt_pkg::MAX_SLOTS_DEF,
  parameter int unsigned PRICE_SCALE = pkt_pkg::PRICE_SCALE_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  pkt_in_if.sink                          in_i,
  pkt_out_if.source                       out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [pkt_pkg::CASH_W-1:0] cfg_data_i
);
  localparam int unsigned IdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned UsedW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned MW    = pkt_pkg::MONEY_W;
  localparam int unsigned SW    = pkt_pkg::SHARE_W;
  localparam int unsigned PW    = pkt_pkg::PRICE_W;
  localparam int unsigned ValW  = SW + PW;
  localparam int unsigned NumW  = MW - 1 + SW;
  localparam logic [PW-1:0] ScaleC = PW'(PRICE_SCALE);

  // One-hot sequencer states.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FIND  = 12'b000000000010,
    S_FILL  = 12'b000000000100,
    S_MUL1  = 12'b000000001000,
    S_MUL2  = 12'b000000010000,
    S_DST   = 12'b000000100000,
    S_DIV   = 12'b000001000000,
    S_SELL  = 12'b000010000000,
    S_SCAN  = 12'b000100000000,
    S_SUM   = 12'b001000000000,
    S_EQ    = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  // Slot memory: one write port, one registered read port.
  pkt_pkg::slot_t mem [MAX_SLOTS];
  pkt_pkg::slot_t rd_data_q;
  logic           mem_we;
  logic [IdxW-1:0] mem_wa;
  pkt_pkg::slot_t mem_wd;

  state_e state_q, state_d;

  // Latched event.
  logic [1:0]       act_q, act_d;
  logic [pkt_pkg::KEY_W-1:0] mkt_q, mkt_d;
  logic             yes_q, yes_d;
  logic             sell_q, sell_d;
  logic [SW-1:0]    sh_q, sh_d;
  logic [PW-1:0]    price_q, price_d;

  // Totals.
  logic [UsedW-1:0]        used_q, used_d;
  logic signed [MW-1:0]    cash_q, cash_d;
  logic signed [MW-1:0]    exp_q, exp_d;
  logic signed [MW-1:0]    unr_q, unr_d;
  logic signed [MW-1:0]    real_q, real_d;
  logic [pkt_pkg::CNT_W-1:0] closed_q, closed_d, win_q, win_d, loss_q, loss_d;
  logic                    full_q, full_d;

  // Scan engine.
  logic [UsedW-1:0]     rd_idx_q, rd_idx_d;
  logic                 pv_q, pv_d;
  logic [IdxW-1:0]      pidx_q, pidx_d;
  logic signed [MW-1:0] acc_q, acc_d;
  logic                 scan_issue, scan_done;

  // Working values of the current slot.
  logic [IdxW-1:0]      sel_q, sel_d;
  pkt_pkg::slot_t       ent_q, ent_d;
  logic [SW-1:0]        close_q, close_d;
  logic [MW-2:0]        ucost_q, ucost_d;
  logic [MW-1:0]        plo_q, plo_d;
  logic [MW-2:0]        phi_q, phi_d;
  logic [ValW-1:0]      cp_q, cp_d;
  logic signed [MW-1:0] pnl_q, pnl_d;
  logic [MW-2:0]        rem_q, rem_d;
  logic signed [MW-1:0] mc_q, mc_d;
  logic signed [MW-1:0] ce_q, ce_d;

  // Divider interface.
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;

  // Output register.
  logic                 ov_q;
  logic signed [MW-1:0] o_cash_q, o_unr_q, o_real_q, o_eq_q;
  logic [MW-2:0]        o_exp_q, o_mc_q;
  logic [pkt_pkg::CNT_W-1:0] o_closed_q, o_win_q, o_loss_q;
  logic                 o_full_q;
  logic                 out_load;

  // Scratch values of the combinational step.
  logic [ValW-1:0]      value;
  logic [SW:0]          nshares;
  logic [ValW-1:0]      prod;
  logic signed [MW-1:0] pnl_s;
  logic                 key_hit;
  pkt_pkg::slot_t       e;

  assign div_num = {phi_q, {SW{1'b0}}} + NumW'(plo_q);

  pkt_div #(
    .NUM_W (NumW),
    .DEN_W (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (ent_q.shares),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign scan_issue = (rd_idx_q < used_q);
  assign scan_done  = !pv_q && !scan_issue;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!ov_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    mkt_d    = mkt_q;
    yes_d    = yes_q;
    sell_d   = sell_q;
    sh_d     = sh_q;
    price_d  = price_q;
    used_d   = used_q;
    cash_d   = cash_q;
    exp_d    = exp_q;
    unr_d    = unr_q;
    real_d   = real_q;
    closed_d = closed_q;
    win_d    = win_q;
    loss_d   = loss_q;
    full_d   = full_q;
    rd_idx_d = rd_idx_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    acc_d    = acc_q;
    sel_d    = sel_q;
    ent_d    = ent_q;
    close_d  = close_q;
    ucost_d  = ucost_q;
    plo_d    = plo_q;
    phi_d    = phi_q;
    cp_d     = cp_q;
    pnl_d    = pnl_q;
    rem_d    = rem_q;
    mc_d     = mc_q;
    ce_d     = ce_q;
    mem_we   = 1'b0;
    mem_wa   = sel_q;
    mem_wd   = ent_q;
    div_start = 1'b0;
    value    = ValW'(sh_q) * ValW'(price_q);
    nshares  = (SW+1)'(ent_q.shares) + (SW+1)'(sh_q);
    prod     = '0;
    pnl_s    = '0;
    e        = rd_data_q;
    key_hit  = (rd_data_q.market == mkt_q) && (rd_data_q.outcome == yes_q);

    // Scan pipeline: issue one read per cycle, process its data in the following cycle.
    if (state_q == S_FIND || state_q == S_SCAN || state_q == S_SUM) begin
      pv_d   = scan_issue;
      pidx_d = rd_idx_q[IdxW-1:0];
      if (scan_issue) begin
        rd_idx_d = rd_idx_q + UsedW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d    = in_i.action;
          mkt_d    = in_i.market_key;
          yes_d    = in_i.outcome_yes;
          sell_d   = in_i.sell_side;
          sh_d     = in_i.share_count;
          price_d  = in_i.price_value;
          full_d   = 1'b0;
          rd_idx_d = '0;
          acc_d    = '0;
          if (in_i.action == pkt_pkg::ACT_FILL && in_i.share_count != '0) begin
            state_d = S_FIND;
          end else if (in_i.action == pkt_pkg::ACT_MARK ||
                       in_i.action == pkt_pkg::ACT_SETTLE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_FIND: begin
        if (pv_q && key_hit) begin
          sel_d   = pidx_q;
          ent_d   = rd_data_q;
          state_d = S_FILL;
        end else if (scan_done) begin
          if (used_q < UsedW'(MAX_SLOTS)) begin
            sel_d          = used_q[IdxW-1:0];
            ent_d          = '0;
            ent_d.market   = mkt_q;
            ent_d.outcome  = yes_q;
            used_d         = used_q + UsedW'(1);
            state_d        = S_FILL;
          end else begin
            full_d   = 1'b1;
            rd_idx_d = '0;
            pv_d     = 1'b0;
            acc_d    = '0;
            state_d  = S_SUM;
          end
        end
      end
      S_FILL: begin
        mem_we   = 1'b1;
        rd_idx_d = '0;
        acc_d    = '0;
        state_d  = S_SUM;
        if (!sell_q) begin
          cash_d = pkt_pkg::sat_add(cash_q, -MW'(value));
          exp_d  = pkt_pkg::sat_add(exp_q, MW'(value));
          mem_wd.shares = nshares[SW] ? '1 : nshares[SW-1:0];
          mem_wd.cost   = pkt_pkg::sat_add(ent_q.cost, MW'(value));
        end else begin
          cash_d = pkt_pkg::sat_add(cash_q, MW'(value));
          if (ent_q.shares != '0) begin
            // Close the held shares at average cost; the slot is rewritten later.
            mem_we  = 1'b0;
            close_d = (sh_q <= ent_q.shares) ? sh_q : ent_q.shares;
            ucost_d = ent_q.cost[MW-1] ? '0 : ent_q.cost[MW-2:0];
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        plo_d   = MW'(ucost_q[SW-1:0]) * MW'(close_q);
        cp_d    = ValW'(close_q) * ValW'(price_q);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        phi_d   = (MW-1)'(ucost_q[MW-2:SW]) * (MW-1)'(close_q);
        state_d = S_DST;
      end
      S_DST: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          rem_d   = div_quot[MW-2:0];
          pnl_d   = MW'(cp_q) - MW'(div_quot[MW-2:0]);
          state_d = S_SELL;
        end
      end
      S_SELL: begin
        real_d   = pkt_pkg::sat_add(real_q, pnl_q);
        closed_d = pkt_pkg::sat_inc(closed_q);
        if (pnl_q > 0) begin
          win_d = pkt_pkg::sat_inc(win_q);
        end else if (pnl_q < 0) begin
          loss_d = pkt_pkg::sat_inc(loss_q);
        end
        exp_d = pkt_pkg::sat_add(exp_q, -MW'(rem_q));
        if (exp_d[MW-1]) begin
          exp_d = '0;
        end
        mem_we        = 1'b1;
        mem_wd.cost   = MW'(ucost_q - rem_q);
        mem_wd.shares = ent_q.shares - close_q;
        rd_idx_d      = '0;
        acc_d         = '0;
        state_d       = S_SUM;
      end
      S_SCAN: begin
        if (pv_q) begin
          mem_wa = pidx_q;
          if (act_q == pkt_pkg::ACT_MARK) begin
            // Update the bid of a matching slot and accumulate unrealized profit.
            if (key_hit) begin
              e.bid  = price_q;
              mem_we = 1'b1;
            end
            mem_wd = e;
            if (e.shares != '0) begin
              prod  = ValW'(e.bid) * ValW'(e.shares);
              acc_d = pkt_pkg::sat_add(acc_q, pkt_pkg::sat_add(MW'(prod), -e.cost));
            end
          end else if (rd_data_q.market == mkt_q && rd_data_q.shares != '0) begin
            // Settle: winning shares pay PRICE_SCALE each, the slot closes.
            if (rd_data_q.outcome == yes_q) begin
              prod = ValW'(rd_data_q.shares) * ValW'(ScaleC);
            end
            pnl_s    = pkt_pkg::sat_add(MW'(prod), -rd_data_q.cost);
            cash_d   = pkt_pkg::sat_add(cash_q, MW'(prod));
            exp_d    = pkt_pkg::sat_add(exp_q, -rd_data_q.cost);
            if (exp_d[MW-1]) begin
              exp_d = '0;
            end
            real_d   = pkt_pkg::sat_add(real_q, pnl_s);
            closed_d = pkt_pkg::sat_inc(closed_q);
            if (pnl_s >= 0) begin
              win_d = pkt_pkg::sat_inc(win_q);
            end else begin
              loss_d = pkt_pkg::sat_inc(loss_q);
            end
            e.shares = '0;
            e.cost   = '0;
            mem_wd   = e;
            mem_we   = 1'b1;
          end
        end else if (scan_done) begin
          if (act_q == pkt_pkg::ACT_MARK) begin
            unr_d = acc_q;
          end
          rd_idx_d = '0;
          acc_d    = '0;
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        if (pv_q) begin
          if (rd_data_q.market == mkt_q && rd_data_q.shares != '0) begin
            acc_d = pkt_pkg::sat_add(acc_q, rd_data_q.cost);
          end
        end else if (scan_done) begin
          mc_d    = acc_q[MW-1] ? '0 : acc_q;
          state_d = S_EQ;
        end
      end
      S_EQ: begin
        ce_d    = pkt_pkg::sat_add(cash_q, exp_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A configuration write loads the starting cash into the balance.
    if (cfg_we_i) begin
      cash_d = MW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      cash_q   <= '0;
      exp_q    <= '0;
      unr_q    <= '0;
      real_q   <= '0;
      closed_q <= '0;
      win_q    <= '0;
      loss_q   <= '0;
      full_q   <= 1'b0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      cash_q   <= cash_d;
      exp_q    <= exp_d;
      unr_q    <= unr_d;
      real_q   <= real_d;
      closed_q <= closed_d;
      win_q    <= win_d;
      loss_q   <= loss_d;
      full_q   <= full_d;
      rd_idx_q <= rd_idx_d;
      pv_q     <= pv_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_d_reg: begin
      act_q   <= act_d;
      mkt_q   <= mkt_d;
      yes_q   <= yes_d;
      sell_q  <= sell_d;
      sh_q    <= sh_d;
      price_q <= price_d;
      pidx_q  <= pidx_d;
      acc_q   <= acc_d;
      sel_q   <= sel_d;
      ent_q   <= ent_d;
      close_q <= close_d;
      ucost_q <= ucost_d;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      cp_q    <= cp_d;
      pnl_q   <= pnl_d;
      rem_q   <= rem_d;
      mc_q    <= mc_d;
      ce_q    <= ce_d;
    end
    if (out_load) begin
      o_cash_q   <= cash_q;
      o_exp_q    <= exp_q[MW-2:0];
      o_unr_q    <= unr_q;
      o_real_q   <= real_q;
      o_eq_q     <= pkt_pkg::sat_add(ce_q, unr_q);
      o_mc_q     <= mc_q[MW-2:0];
      o_closed_q <= closed_q;
      o_win_q    <= win_q;
      o_loss_q   <= loss_q;
      o_full_q   <= full_q;
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.cash_balance     = o_cash_q;
  assign out_o.exposure_total   = o_exp_q;
  assign out_o.unrealized_total = o_unr_q;
  assign out_o.realized_total   = o_real_q;
  assign out_o.equity_value     = o_eq_q;
  assign out_o.market_cost      = o_mc_q;
  assign out_o.closed_trades    = o_closed_q;
  assign out_o.win_trades       = o_win_q;
  assign out_o.loss_trades      = o_loss_q;
  assign out_o.table_full       = o_full_q;
endmodule
`default_nettype wire

/* design/pkt_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial restoring divider, one quotient bit per cycle.
module pkt_div #(
  parameter int unsigned NUM_W = 95,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

/* sim/position_keeping_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the position keeping table with its own accounting predictor.
module position_keeping_table_tb;

  localparam int           SLOT_CNT     = 64;
  localparam longint       SCALE        = 1000000;
  localparam int           CYCLE_LIMIT  = 2000000;
  localparam logic [61:0]  CASH_TOP     = '1;
  localparam logic signed [63:0] MONEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MONEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [1:0]   ACT_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] market;
    logic        yes;
    logic        sell;
    logic [31:0] shares;
    logic [19:0] price;
  } event_t;

  typedef struct packed {
    logic signed [63:0] cash;
    logic [62:0]        exposure;
    logic signed [63:0] unrealized;
    logic signed [63:0] realized;
    logic signed [63:0] equity;
    logic [62:0]        mkt_cost;
    logic [31:0]        closed;
    logic [31:0]        wins;
    logic [31:0]        losses;
    logic               full;
  } totals_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pkt_pkg::CASH_W-1:0] cfg_data;

  pkt_in_if  ev_if ();
  pkt_out_if res_if ();

  position_keeping_table dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (ev_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: the position table and the running totals.
  logic [31:0]        pos_mkt  [SLOT_CNT];
  logic               pos_yes  [SLOT_CNT];
  logic [31:0]        pos_sh   [SLOT_CNT];
  logic signed [63:0] pos_cost [SLOT_CNT];
  logic [19:0]        pos_bid  [SLOT_CNT];
  int                 pos_used;
  logic signed [63:0] cash_acc, expo_acc, unrl_acc, real_acc;
  logic [31:0]        n_closed, n_wins, n_losses;

  event_t  pending_events[$];
  totals_t expected_totals[$];
  int      tx_idle, rx_idle;
  int      mismatches, results_seen, full_seen, cycles;
  int      act_seen[4];

  // Signed add that clips at the 64-bit limits instead of wrapping.
  function automatic logic signed [63:0] clip_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? MONEY_MIN : MONEY_MAX;
    return s[63:0];
  endfunction

  function automatic void bump(inout logic [31:0] c);
    if (c != '1) c = c + 1;
  endfunction

  // Looks up the slot of a key, allocating a fresh one when there is room; -1 when full.
  function automatic int slot_of(input logic [31:0] mkt, input logic yes);
    for (int i = 0; i < pos_used; i++) begin
      if (pos_mkt[i] == mkt && pos_yes[i] == yes) return i;
    end
    if (pos_used < SLOT_CNT) begin
      pos_mkt[pos_used]  = mkt;
      pos_yes[pos_used]  = yes;
      pos_sh[pos_used]   = '0;
      pos_cost[pos_used] = '0;
      pos_bid[pos_used]  = '0;
      pos_used++;
      return pos_used - 1;
    end
    return -1;
  endfunction

  // Applies one accepted event to the predicted book and returns the totals it reports.
  function automatic totals_t book_event(input event_t e);
    totals_t t;
    int s;
    logic signed [63:0] value, pnl, sum, v, pay;
    logic [63:0] cost_u, q, r, removed;
    logic [32:0] grown;
    logic [31:0] held, closed;
    t.full = 1'b0;
    case (e.action)
      pkt_pkg::ACT_FILL: begin
        if (e.shares != 0) begin
          s = slot_of(e.market, e.yes);
          if (s < 0) begin
            t.full = 1'b1;
          end else begin
            value = 64'(e.shares) * 64'(e.price);
            if (!e.sell) begin
              cash_acc = clip_add(cash_acc, -value);
              grown = 33'(pos_sh[s]) + 33'(e.shares);
              pos_sh[s] = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
              pos_cost[s] = clip_add(pos_cost[s], value);
              expo_acc = clip_add(expo_acc, value);
            end else begin
              cash_acc = clip_add(cash_acc, value);
              held = pos_sh[s];
              if (held != 0) begin
                closed = (e.shares <= held) ? e.shares : held;
                cost_u = pos_cost[s] < 0 ? 64'd0 : pos_cost[s];
                q = cost_u / held;
                r = cost_u % held;
                // Exact floor of cost * closed / held without a 96-bit product.
                removed = q * closed + (r * closed) / held;
                pnl = $signed(64'(closed) * 64'(e.price)) - $signed(removed);
                real_acc = clip_add(real_acc, pnl);
                bump(n_closed);
                if (pnl > 0) bump(n_wins);
                else if (pnl < 0) bump(n_losses);
                pos_cost[s] = cost_u - removed;
                pos_sh[s] = held - closed;
                expo_acc = clip_add(expo_acc, -$signed(removed));
                if (expo_acc < 0) expo_acc = 0;
              end
            end
          end
        end
      end
      pkt_pkg::ACT_MARK: begin
        sum = 0;
        for (int i = 0; i < pos_used; i++) begin
          if (pos_mkt[i] == e.market && pos_yes[i] == e.yes) pos_bid[i] = e.price;
          if (pos_sh[i] > 0) begin
            v = 64'(pos_bid[i]) * 64'(pos_sh[i]);
            sum = clip_add(sum, clip_add(v, -pos_cost[i]));
          end
        end
        unrl_acc = sum;
      end
      pkt_pkg::ACT_SETTLE: begin
        for (int i = 0; i < pos_used; i++) begin
          if (pos_mkt[i] == e.market && pos_sh[i] > 0) begin
            pay = (pos_yes[i] == e.yes) ? 64'(pos_sh[i]) * SCALE : 64'sd0;
            pnl = clip_add(pay, -pos_cost[i]);
            cash_acc = clip_add(cash_acc, pay);
            expo_acc = clip_add(expo_acc, -pos_cost[i]);
            if (expo_acc < 0) expo_acc = 0;
            real_acc = clip_add(real_acc, pnl);
            bump(n_closed);
            if (pnl >= 0) bump(n_wins);
            else bump(n_losses);
            pos_sh[i] = '0;
            pos_cost[i] = '0;
          end
        end
      end
      default: ;
    endcase
    sum = 0;
    for (int i = 0; i < pos_used; i++) begin
      if (pos_mkt[i] == e.market && pos_sh[i] > 0) sum = clip_add(sum, pos_cost[i]);
    end
    if (sum < 0) sum = 0;
    t.cash       = cash_acc;
    t.exposure   = expo_acc[62:0];
    t.unrealized = unrl_acc;
    t.realized   = real_acc;
    t.equity     = clip_add(clip_add(cash_acc, expo_acc), unrl_acc);
    t.mkt_cost   = sum[62:0];
    t.closed     = n_closed;
    t.wins       = n_wins;
    t.losses     = n_losses;
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Event driver: presents the next pending event, holding it until the transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (ev_if.valid && ev_if.ready) begin
        act_seen[ev_if.action]++;
        expected_totals.push_back(book_event('{ev_if.action, ev_if.market_key,
            ev_if.outcome_yes, ev_if.sell_side, ev_if.share_count, ev_if.price_value}));
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= tx_idle) begin
          ev_if.valid       <= 1'b1;
          ev_if.action      <= pending_events[0].action;
          ev_if.market_key  <= pending_events[0].market;
          ev_if.outcome_yes <= pending_events[0].yes;
          ev_if.sell_side   <= pending_events[0].sell;
          ev_if.share_count <= pending_events[0].shares;
          ev_if.price_value <= pending_events[0].price;
          void'(pending_events.pop_front());
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, whole-result check against the oldest prediction.
  always @(posedge clk) begin
    totals_t w;
    totals_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_totals.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.cash_balance, res_if.exposure_total, res_if.unrealized_total,
                res_if.realized_total, res_if.equity_value, res_if.market_cost,
                res_if.closed_trades, res_if.win_trades, res_if.loss_trades,
                res_if.table_full};
        results_seen++;
        if (got.full) full_seen++;
        if (expected_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          w = expected_totals.pop_front();
          if (got !== w) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected %p", w);
              $display("  actual   %p", got);
            end
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic queue_event(input logic [1:0] a, input logic [31:0] m, input logic y,
                             input logic sl, input logic [31:0] sh, input logic [19:0] p);
    pending_events.push_back('{a, m, y, sl, sh, p});
  endtask

  // Random event: keys come mostly from a pool a bit larger than the table, so positions
  // are reused for buy/sell/mark/settle sequences and the table eventually fills up.
  task automatic queue_random_event();
    int r, k;
    logic [1:0]  a;
    logic [31:0] m, sh;
    logic [19:0] p;
    r = $urandom_range(99);
    a = r < 55 ? pkt_pkg::ACT_FILL : r < 78 ? pkt_pkg::ACT_MARK
                                   : r < 95 ? pkt_pkg::ACT_SETTLE : ACT_NONE;
    k = $urandom_range(35);
    if ($urandom_range(99) < 8) m = $urandom;
    else m = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : k * 32'h0100_0193;
    r = $urandom_range(99);
    sh = r < 5 ? 32'd0 : r < 9 ? 32'hFFFF_FFFF : r < 18 ? $urandom : $urandom_range(1, 5000);
    r = $urandom_range(99);
    p = r < 5 ? 20'd0 : r < 10 ? 20'hFFFFF : r < 60 ? 20'($urandom_range(0, 1000000))
                                                    : 20'($urandom);
    queue_event(a, m, 1'($urandom), 1'($urandom), sh, p);
  endtask

  // Checked on the falling edge, when the driver's updates of the rising edge have settled.
  task automatic wait_drained();
    while (pending_events.size() != 0 || ev_if.valid || expected_totals.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start_cash(input logic [61:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    cash_acc = $signed({2'b00, v});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [61:0] start, input int tx, input int rx, input int n);
    write_start_cash(start);
    tx_idle = tx;
    rx_idle = rx;
    repeat (n) queue_random_event();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    ev_if.valid = 1'b0;
    ev_if.action = pkt_pkg::ACT_FILL;
    ev_if.market_key = '0;
    ev_if.outcome_yes = 1'b0;
    ev_if.sell_side = 1'b0;
    ev_if.share_count = '0;
    ev_if.price_value = '0;
    res_if.ready = 1'b0;
    pos_used = 0;
    cash_acc = 0; expo_acc = 0; unrl_acc = 0; real_acc = 0;
    n_closed = 0; n_wins = 0; n_losses = 0;
    mismatches = 0; results_seen = 0; full_seen = 0; cycles = 0;
    act_seen = '{0, 0, 0, 0};
    tx_idle = 17;
    rx_idle = 66;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run from the reset value of the starting cash.
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b1, 1'b0, 32'd100, 20'd400000);   // plain buy
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b1, 1'b0, 32'd3, 20'd650001);     // uneven average
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b1, 1'b1, 32'd41, 20'd700000);    // partial close
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b1, 1'b1, 32'd500, 20'd10);       // oversell, loss
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b1, 1'b1, 32'd5, 20'd300000);     // none held
    queue_event(pkt_pkg::ACT_FILL, 32'd9, 1'b0, 1'b0, 32'd0, 20'hFFFFF);      // zero shares
    queue_event(pkt_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_event(pkt_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF,
                20'hFFFFF);                                                   // share clip
    queue_event(pkt_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd2000, 20'd0); // free shares
    queue_event(pkt_pkg::ACT_MARK, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 20'd999999);
    queue_event(pkt_pkg::ACT_MARK, 32'd12345, 1'b1, 1'b1, 32'hFFFF_FFFF, 20'd5); // absent key
    queue_event(pkt_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd1000, 20'd0); // zero profit
    queue_event(pkt_pkg::ACT_SETTLE, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 20'd0);  // win and loss
    queue_event(pkt_pkg::ACT_FILL, 32'd0, 1'b0, 1'b0, 32'd10, 20'd1000000);
    queue_event(pkt_pkg::ACT_SETTLE, 32'd0, 1'b0, 1'b1, 32'd1, 20'd1);        // zero profit win
    queue_event(pkt_pkg::ACT_SETTLE, 32'd0, 1'b1, 1'b0, 32'd1, 20'd1);        // nothing open
    queue_event(ACT_NONE, 32'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 20'hFFFFF);       // unused code
    queue_event(pkt_pkg::ACT_FILL, 32'd7, 1'b0, 1'b0, 32'd1, 20'd1);
    queue_event(pkt_pkg::ACT_MARK, 32'd7, 1'b0, 1'b0, 32'd1, 20'hFFFFF);
    queue_event(pkt_pkg::ACT_SETTLE, 32'd7, 1'b1, 1'b1, 32'd0, 20'd0);
    wait_drained();

    run_phase(CASH_TOP, 17, 66, 460);
    run_phase(62'({$urandom, $urandom}), 66, 17, 460);
    run_phase('0, 0, 0, 460);

    $display("covered %0d fills, %0d marks, %0d settles, %0d unused-code events",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
    $display("%0d results checked, %0d dropped on a full table, %0d slots in use, %0d errors",
             results_seen, full_seen, pos_used, mismatches);
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
